@@ rtl/rfpm_pkg.sv @@
// ----------------------------------------------------------------------------
// rfpm_pkg
// shared types, constants and helpers of the rfid frame parser and matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfpm_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ID_BYTES      = 5;
  localparam int PAYLOAD_CHARS = 12;

  localparam int ID_W       = 8 * ID_BYTES;
  localparam int ID_CHARS   = 2 * ID_BYTES;
  localparam int CNT_W      = $clog2(PAYLOAD_CHARS + 1);
  localparam int TBL_IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CARD_W     = $clog2(TABLE_ENTRIES + 1);

  localparam int OPCODE_W      = 1;
  localparam int RX_BYTE_W     = 8;
  localparam int ENTRY_INDEX_W = 4;
  localparam int CARD_ID_W     = 40;
  localparam int CARD_NUMBER_W = 5;

  localparam logic [OPCODE_W-1:0] OP_RX_BYTE   = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_TBL_WRITE = 1'b1;

  localparam logic [7:0] BYTE_STX  = 8'h02;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_ETX  = 8'h03;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A    = 8'h41;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_PAYLOAD,
    PH_CR,
    PH_LF,
    PH_ETX
  } parse_phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SCAN,
    SQ_DONE
  } seq_state_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - CHAR_ZERO;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - CHAR_A + 8'd10;
    end
    return d[3:0];
  endfunction

endpackage

@@ rtl/rfpm_in_if.sv @@
// ----------------------------------------------------------------------------
// rfpm_in_if
// input channel: received bytes and card table writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rfpm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rfpm_pkg::OPCODE_W-1:0]        opcode;
  logic [rfpm_pkg::RX_BYTE_W-1:0]       rx_byte;
  logic [rfpm_pkg::ENTRY_INDEX_W-1:0]   entry_index;
  logic [rfpm_pkg::CARD_ID_W-1:0]       entry_id;
  logic                                 entry_valid;

  modport source (
    output valid, opcode, rx_byte, entry_index, entry_id, entry_valid,
    input  ready
  );
  modport sink (
    input  valid, opcode, rx_byte, entry_index, entry_id, entry_valid,
    output ready
  );
endinterface

@@ rtl/rfpm_out_if.sv @@
// ----------------------------------------------------------------------------
// rfpm_out_if
// result channel: matched card number and decoded card id
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rfpm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [rfpm_pkg::CARD_NUMBER_W-1:0]   card_number;
  logic [rfpm_pkg::CARD_ID_W-1:0]       card_id;
  logic                                 known_card;

  modport source (
    output valid, card_number, card_id, known_card,
    input  ready
  );
  modport sink (
    input  valid, card_number, card_id, known_card,
    output ready
  );
endinterface

@@ rtl/rfid_frame_parse_and_match_core.sv @@
// ----------------------------------------------------------------------------
// rfid_frame_parse_and_match_core
// parses stx/hex/cr/lf/etx reader frames and matches the card id in a table
// sequence: a byte or table write is taken in idle; a new frame id moves the
//   sequencer to scan, which compares entries in order up to the first hit (at
//   most TABLE_ENTRIES), then done loads the output register, then the transfer
// throughput: one item per cycle; a new frame id holds off input during its
//   table scan and while the previous result still waits in the output register
// reset: synchronous, clears parser, last id, card number and all valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfid_frame_parse_and_match_core (
  input  logic      clk,
  input  logic      rst_n,
  rfpm_in_if.sink   in_ch,
  rfpm_out_if.source out_ch
);

  rfpm_pkg::seq_state_t                 sq_r, sq_nxt;
  rfpm_pkg::parse_phase_t               phase_r, phase_nxt;
  logic [rfpm_pkg::CNT_W-1:0]           char_count_r, char_count_nxt;
  logic [rfpm_pkg::ID_W-1:0]            id_shift_r, id_shift_nxt;
  logic [rfpm_pkg::ID_W-1:0]            last_id_r, last_id_nxt;
  logic [rfpm_pkg::CARD_W-1:0]          current_card_r, current_card_nxt;
  logic [rfpm_pkg::TBL_IDX_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic                                 hit_r, hit_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic [rfpm_pkg::CARD_W-1:0]          out_card_r, out_card_nxt;
  logic [rfpm_pkg::ID_W-1:0]            out_id_r, out_id_nxt;
  logic                                 out_known_r, out_known_nxt;

  logic [rfpm_pkg::TABLE_ENTRIES-1:0]   tbl_valid_r;
  logic [rfpm_pkg::CARD_ID_W-1:0]       tbl_id_r [rfpm_pkg::TABLE_ENTRIES];

  logic                                 in_xfer;
  logic                                 out_xfer;
  logic                                 tbl_we;
  logic [rfpm_pkg::TBL_IDX_W-1:0]       tbl_waddr;
  logic                                 entry_match;
  logic [3:0]                           nib;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_ch.valid && out_ch.ready;
  assign tbl_waddr = rfpm_pkg::TBL_IDX_W'(in_ch.entry_index);
  assign tbl_we    = in_xfer && (in_ch.opcode == rfpm_pkg::OP_TBL_WRITE) &&
                     (32'(in_ch.entry_index) < rfpm_pkg::TABLE_ENTRIES);
  assign nib       = rfpm_pkg::hex_nibble(in_ch.rx_byte);

  // shared comparator, one table entry per cycle
  assign entry_match = tbl_valid_r[scan_idx_r] &&
                       (tbl_id_r[scan_idx_r] == rfpm_pkg::CARD_ID_W'(id_shift_r));

  assign in_ch.ready        = (sq_r == rfpm_pkg::SQ_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.card_number = rfpm_pkg::CARD_NUMBER_W'(out_card_r);
  assign out_ch.card_id     = rfpm_pkg::CARD_ID_W'(out_id_r);
  assign out_ch.known_card  = out_known_r;

  always_comb begin
    sq_nxt           = sq_r;
    phase_nxt        = phase_r;
    char_count_nxt   = char_count_r;
    id_shift_nxt     = id_shift_r;
    last_id_nxt      = last_id_r;
    current_card_nxt = current_card_r;
    scan_idx_nxt     = scan_idx_r;
    hit_nxt          = hit_r;
    out_valid_nxt    = out_valid_r;
    out_card_nxt     = out_card_r;
    out_id_nxt       = out_id_r;
    out_known_nxt    = out_known_r;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    case (sq_r)
      rfpm_pkg::SQ_IDLE: begin
        if (in_xfer && (in_ch.opcode == rfpm_pkg::OP_RX_BYTE)) begin
          if (in_ch.rx_byte == rfpm_pkg::BYTE_STX) begin
            phase_nxt      = rfpm_pkg::PH_PAYLOAD;
            char_count_nxt = '0;
            id_shift_nxt   = '0;
          end else begin
            case (phase_r)
              rfpm_pkg::PH_PAYLOAD: begin
                if (32'(char_count_r) < rfpm_pkg::ID_CHARS) begin
                  id_shift_nxt = {id_shift_r[rfpm_pkg::ID_W-5:0], nib};
                end
                if (32'(char_count_r) + 1 >= rfpm_pkg::PAYLOAD_CHARS) begin
                  phase_nxt      = rfpm_pkg::PH_CR;
                  char_count_nxt = '0;
                end else begin
                  char_count_nxt = char_count_r + 1'b1;
                end
              end
              rfpm_pkg::PH_CR: begin
                phase_nxt = (in_ch.rx_byte == rfpm_pkg::BYTE_CR) ?
                            rfpm_pkg::PH_LF : rfpm_pkg::PH_HUNT;
              end
              rfpm_pkg::PH_LF: begin
                phase_nxt = (in_ch.rx_byte == rfpm_pkg::BYTE_LF) ?
                            rfpm_pkg::PH_ETX : rfpm_pkg::PH_HUNT;
              end
              rfpm_pkg::PH_ETX: begin
                phase_nxt = rfpm_pkg::PH_HUNT;
                if ((in_ch.rx_byte == rfpm_pkg::BYTE_ETX) &&
                    (id_shift_r != last_id_r)) begin
                  sq_nxt       = rfpm_pkg::SQ_SCAN;
                  scan_idx_nxt = '0;
                  hit_nxt      = 1'b0;
                end
              end
              default: begin
                phase_nxt = rfpm_pkg::PH_HUNT;
              end
            endcase
          end
        end
      end
      rfpm_pkg::SQ_SCAN: begin
        if (entry_match) begin
          hit_nxt          = 1'b1;
          current_card_nxt = rfpm_pkg::CARD_W'(scan_idx_r) + 1'b1;
          last_id_nxt      = id_shift_r;
          sq_nxt           = rfpm_pkg::SQ_DONE;
        end else if (scan_idx_r ==
                     rfpm_pkg::TBL_IDX_W'(rfpm_pkg::TABLE_ENTRIES - 1)) begin
          last_id_nxt = id_shift_r;
          sq_nxt      = rfpm_pkg::SQ_DONE;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      rfpm_pkg::SQ_DONE: begin
        // output register free or freed by this transfer
        if (!out_valid_r || out_xfer) begin
          out_valid_nxt = 1'b1;
          out_card_nxt  = current_card_r;
          out_id_nxt    = last_id_r;
          out_known_nxt = hit_r;
          sq_nxt        = rfpm_pkg::SQ_IDLE;
        end
      end
      default: begin
        sq_nxt = rfpm_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r           <= rfpm_pkg::SQ_IDLE;
      phase_r        <= rfpm_pkg::PH_HUNT;
      char_count_r   <= '0;
      id_shift_r     <= '0;
      last_id_r      <= '0;
      current_card_r <= '0;
      scan_idx_r     <= '0;
      hit_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      out_card_r     <= '0;
      out_id_r       <= '0;
      out_known_r    <= 1'b0;
    end else begin
      sq_r           <= sq_nxt;
      phase_r        <= phase_nxt;
      char_count_r   <= char_count_nxt;
      id_shift_r     <= id_shift_nxt;
      last_id_r      <= last_id_nxt;
      current_card_r <= current_card_nxt;
      scan_idx_r     <= scan_idx_nxt;
      hit_r          <= hit_nxt;
      out_valid_r    <= out_valid_nxt;
      out_card_r     <= out_card_nxt;
      out_id_r       <= out_id_nxt;
      out_known_r    <= out_known_nxt;
    end
  end

  // valid bits cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_valid_r <= '0;
    end else if (tbl_we) begin
      tbl_valid_r[tbl_waddr] <= in_ch.entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_id_r[tbl_waddr] <= in_ch.entry_id;
    end
  end

  a_result_held: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_card_r) && $stable(out_id_r) && $stable(out_known_r))
  ) else $error("waiting result changed before its transfer");

  a_known_has_number: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.known_card) |-> (out_ch.card_number != '0)
  ) else $error("known card without a card number");

  a_scan_starts_at_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (sq_r == rfpm_pkg::SQ_IDLE && sq_nxt == rfpm_pkg::SQ_SCAN)
      |=> (scan_idx_r == '0)
  ) else $error("table scan does not start at entry zero");

  a_load_when_free: assert property (
    @(posedge clk) disable iff (!rst_n)
    (sq_r == rfpm_pkg::SQ_DONE && (!out_valid_r || out_xfer))
      |=> (out_ch.valid && in_ch.ready)
  ) else $error("result not loaded or input not released");

  a_result_id_new: assert property (
    @(posedge clk) disable iff (!rst_n)
    (sq_r == rfpm_pkg::SQ_SCAN && sq_nxt == rfpm_pkg::SQ_DONE)
      |=> (last_id_r == $past(id_shift_r))
  ) else $error("last id not taken from the frame");

endmodule

@@ dv/rfid_frame_parse_and_match_core_test.sv @@
// ----------------------------------------------------------------------------
// rfid_frame_parse_and_match_core_test
// self-checking bench for the rfid frame parser and card matcher: drives
// received bytes and card table writes with random gaps and output stalls,
// predicts each result with a bit-accurate parser and table model, and
// compares every result transfer field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfid_frame_parse_and_match_core_test;
  import rfpm_pkg::*;

  localparam int FRAME_LEN   = PAYLOAD_CHARS + 4;
  localparam int RX_ITEMS    = 950;
  localparam int HOLD_CYCLES = 400;
  localparam int POOL_SIZE   = 6;

  typedef struct packed {
    logic [OPCODE_W-1:0]      op;
    logic [RX_BYTE_W-1:0]     rx;
    logic [ENTRY_INDEX_W-1:0] idx;
    logic [CARD_ID_W-1:0]     id;
    logic                     usable;
  } feed_item_t;

  typedef struct packed {
    logic [CARD_NUMBER_W-1:0] number;
    logic [CARD_ID_W-1:0]     id;
    logic                     known;
  } card_result_t;

  typedef enum int {
    FL_NONE,
    FL_NON_HEX,
    FL_BAD_CR,
    FL_BAD_LF,
    FL_BAD_ETX,
    FL_RESTART,
    FL_TABLE_WRITE
  } frame_flaw_t;

  logic clk;
  logic rst_n;

  rfpm_in_if  in_ch ();
  rfpm_out_if out_ch ();

  rfid_frame_parse_and_match_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  class card_scoreboard;
    parse_phase_t             phase;
    int                       taken;
    logic [ID_W-1:0]          id_accum;
    logic [ID_W-1:0]          last_id;
    logic [CARD_NUMBER_W-1:0] card_no;
    logic [CARD_ID_W-1:0]     slot_id [TABLE_ENTRIES];
    bit                       slot_ok [TABLE_ENTRIES];
    card_result_t             card_q [$];
    int                       n_errors;

    function new();
      phase    = PH_HUNT;
      taken    = 0;
      id_accum = '0;
      last_id  = '0;
      card_no  = '0;
      n_errors = 0;
      foreach (slot_id[i]) begin
        slot_id[i] = '0;
        slot_ok[i] = 1'b0;
      end
    endfunction

    function logic [3:0] digit_value(logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= CHAR_ZERO && c < CHAR_ZERO + 8'd10) begin
        v = c - CHAR_ZERO;
      end else if (c >= CHAR_A && c < CHAR_A + 8'd6) begin
        v = c - CHAR_A + 8'd10;
      end
      return v[3:0];
    endfunction

    function void close_frame();
      card_result_t r;
      bit hit;
      hit = 1'b0;
      if (id_accum == last_id) return;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!hit && slot_ok[i] && slot_id[i] == id_accum) begin
          hit     = 1'b1;
          card_no = CARD_NUMBER_W'(i + 1);
        end
      end
      last_id  = id_accum;
      r.number = card_no;
      r.id     = id_accum;
      r.known  = hit;
      card_q.push_back(r);
    endfunction

    function void note_input(feed_item_t it);
      if (it.op == OP_TBL_WRITE) begin
        slot_id[it.idx] = it.id;
        slot_ok[it.idx] = it.usable;
        return;
      end
      if (it.rx == BYTE_STX) begin
        phase    = PH_PAYLOAD;
        taken    = 0;
        id_accum = '0;
        return;
      end
      case (phase)
        PH_PAYLOAD: begin
          if (taken < ID_CHARS) id_accum = {id_accum[ID_W-5:0], digit_value(it.rx)};
          taken++;
          if (taken >= PAYLOAD_CHARS) begin
            phase = PH_CR;
            taken = 0;
          end
        end
        PH_CR: phase = (it.rx == BYTE_CR) ? PH_LF : PH_HUNT;
        PH_LF: phase = (it.rx == BYTE_LF) ? PH_ETX : PH_HUNT;
        PH_ETX: begin
          phase = PH_HUNT;
          if (it.rx == BYTE_ETX) close_frame();
        end
        default: phase = PH_HUNT;
      endcase
    endfunction

    function void check_result(card_result_t got);
      card_result_t want;
      if (card_q.size() == 0) begin
        n_errors++;
        $display("%0t unexpected result: card_number %0d card_id %h known_card %0d",
                 $time, got.number, got.id, got.known);
        return;
      end
      want = card_q.pop_front();
      if (got.number !== want.number) begin
        n_errors++;
        $display("%0t card_number expected %0d actual %0d", $time, want.number, got.number);
      end
      if (got.id !== want.id) begin
        n_errors++;
        $display("%0t card_id expected %h actual %h", $time, want.id, got.id);
      end
      if (got.known !== want.known) begin
        n_errors++;
        $display("%0t known_card expected %0d actual %0d", $time, want.known, got.known);
      end
    endfunction

    function int pending();
      return card_q.size();
    endfunction
  endclass

  card_scoreboard      sb;
  bit                  steady;
  bit                  hold_req;
  int                  items_sent;
  logic [CARD_ID_W-1:0] id_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CARD_ID_W-1:0] rand_id();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[CARD_ID_W-1:0];
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CHAR_ZERO + {4'h0, n};
    return CHAR_A + {4'h0, n} - 8'd10;
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return (c >= CHAR_ZERO && c < CHAR_ZERO + 8'd10) || (c >= CHAR_A && c < CHAR_A + 8'd6);
  endfunction

  // lowercase a to f half the time, otherwise any non-hex byte other than stx
  function automatic logic [7:0] odd_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return 8'h61 + 8'($urandom_range(0, 5));
    do c = 8'($urandom_range(0, 255)); while (is_hex(c) || c == BYTE_STX);
    return c;
  endfunction

  function automatic logic [7:0] wrong_byte(logic [7:0] good);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == good || c == BYTE_STX);
    return c;
  endfunction

  function automatic feed_item_t rx_item(logic [7:0] b);
    feed_item_t it;
    it.op     = OP_RX_BYTE;
    it.rx     = b;
    it.idx    = ENTRY_INDEX_W'($urandom_range(0, 15));
    it.id     = rand_id();
    it.usable = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(input feed_item_t it);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= it.op;
    in_ch.rx_byte     <= it.rx;
    in_ch.entry_index <= it.idx;
    in_ch.entry_id    <= it.id;
    in_ch.entry_valid <= it.usable;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(it);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(rx_item(b));
    items_sent++;
  endtask

  task automatic send_noise(input logic [7:0] b);
    send_item(rx_item(b));
  endtask

  task automatic write_slot(input int idx, input logic [CARD_ID_W-1:0] id, input bit usable);
    feed_item_t it;
    it.op     = OP_TBL_WRITE;
    it.rx     = 8'($urandom_range(0, 255));
    it.idx    = ENTRY_INDEX_W'(idx);
    it.id     = id;
    it.usable = usable;
    send_item(it);
    items_sent++;
  endtask

  function automatic logic [CARD_ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 7) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return rand_id();
  endfunction

  task automatic send_frame(input logic [CARD_ID_W-1:0] id, input frame_flaw_t flaw);
    logic [7:0] fb [FRAME_LEN];
    int pos;
    int cut;
    pos = -1;
    fb[0] = BYTE_STX;
    for (int i = 0; i < ID_CHARS; i++) fb[1+i] = hex_char(id[ID_W-1-4*i -: 4]);
    for (int i = ID_CHARS; i < PAYLOAD_CHARS; i++) fb[1+i] = hex_char(4'($urandom_range(0, 15)));
    fb[PAYLOAD_CHARS+1] = BYTE_CR;
    fb[PAYLOAD_CHARS+2] = BYTE_LF;
    fb[PAYLOAD_CHARS+3] = BYTE_ETX;
    case (flaw)
      FL_NON_HEX: fb[$urandom_range(1, PAYLOAD_CHARS)] = odd_char();
      FL_BAD_CR:  fb[PAYLOAD_CHARS+1] = wrong_byte(BYTE_CR);
      FL_BAD_LF:  fb[PAYLOAD_CHARS+2] = wrong_byte(BYTE_LF);
      FL_BAD_ETX: fb[PAYLOAD_CHARS+3] = wrong_byte(BYTE_ETX);
      FL_RESTART: begin
        // partial frame cut anywhere up to the etx phase, then a fresh start
        cut = $urandom_range(1, FRAME_LEN - 1);
        for (int i = 0; i < cut; i++) send_byte(fb[i]);
      end
      FL_TABLE_WRITE: pos = $urandom_range(1, FRAME_LEN - 1);
      default: ;
    endcase
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i == pos) write_slot($urandom_range(0, 15), pick_id(), $urandom_range(0, 3) != 0);
      send_byte(fb[i]);
    end
  endtask

  function automatic frame_flaw_t pick_flaw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FL_NONE;
    if (r < 63) return FL_NON_HEX;
    if (r < 70) return FL_BAD_CR;
    if (r < 77) return FL_BAD_LF;
    if (r < 84) return FL_BAD_ETX;
    if (r < 92) return FL_RESTART;
    return FL_TABLE_WRITE;
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    card_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.number = out_ch.card_number;
        got.id     = out_ch.card_id;
        got.known  = out_ch.known_card;
        sb.check_result(got);
      end
    end
  end

  initial begin
    int sel;
    bit hold_done;
    sb         = new();
    steady     = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    items_sent = 0;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_RX_BYTE;
    in_ch.rx_byte     <= '0;
    in_ch.entry_index <= '0;
    in_ch.entry_id    <= '0;
    in_ch.entry_valid <= 1'b0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_noise(8'h00);
    send_noise(8'hFF);
    send_frame('0, FL_NONE);
    write_slot(0, '1, 1'b1);
    write_slot(15, 40'h0123456789, 1'b1);
    write_slot(3, '0, 1'b0);
    write_slot(9, '1, 1'b1);
    send_frame('1, FL_NONE);
    send_frame('1, FL_NONE);
    send_frame(40'h0123456789, FL_RESTART);
    send_frame(40'hABCDEF0123, FL_NON_HEX);
    send_frame('0, FL_BAD_ETX);
    send_frame('0, FL_NONE);
    write_slot(0, '1, 1'b0);
    send_frame('1, FL_NONE);

    // random
    for (int i = 0; i < POOL_SIZE; i++) begin
      id_pool[i] = rand_id();
      write_slot($urandom_range(0, 15), id_pool[i], 1'b1);
    end
    while (items_sent < RX_ITEMS) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if (!hold_done && items_sent > RX_ITEMS / 2) begin
        hold_done = 1'b1;
        steady    = 1'b1;
        hold_req  = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        write_slot($urandom_range(0, 15), pick_id(), $urandom_range(0, 3) != 0);
      end else if (sel < 18) begin
        repeat ($urandom_range(1, 4)) send_noise(8'($urandom_range(0, 255)));
      end else begin
        send_frame(pick_id(), pick_flaw());
      end
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
